/* hw/rtl/rhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned QUO_W  = 16;
	localparam int unsigned REM_W  = 9;
	localparam int unsigned NCELLS = QUO_W;

	localparam logic [7:0] HUE_SECTOR = 8'd60;
	localparam logic [8:0] HUE_GREEN  = 9'd120;
	localparam logic [8:0] HUE_BLUE   = 9'd240;
	localparam logic [8:0] HUE_WRAP   = 9'd360;
	localparam logic [7:0] SAT_SCALE  = 8'd255;

	// one restoring-division lane
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] dvs;
		logic [QUO_W-1:0] low;
		logic [QUO_W-1:0] quo;
	} rhsv_lane_t;

	typedef struct packed {
		rhsv_lane_t        hue;
		rhsv_lane_t        sat;
		logic [CHAN_W-1:0] val;
	} rhsv_cell_t;

endpackage

/* hw/rtl/rhsv_front.sv */
// ----------------------------------------------------------------------------
// rhsv_front
// Max/min/delta and hue numerator; loads both division lanes.
// ----------------------------------------------------------------------------
module rhsv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	output logic                valid_s1,
	output rhsv_pkg::rhsv_cell_t cell_s1
);
	import rhsv_pkg::*;

	logic [7:0]         mx, mn, delta;
	logic signed [18:0] num;
	logic [16:0]        hnum;
	logic [15:0]        sprod;
	rhsv_cell_t         cell_d;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		if (mx == red) begin
			num = $signed({1'b0, HUE_SECTOR}) * ($signed({11'b0, green}) - $signed({11'b0, blue}));
			if (num < 0) num = num + $signed({1'b0, HUE_WRAP}) * $signed({11'b0, delta});
		end else if (mx == green) begin
			num = $signed({1'b0, HUE_GREEN}) * $signed({11'b0, delta})
				+ $signed({1'b0, HUE_SECTOR}) * ($signed({11'b0, blue}) - $signed({11'b0, red}));
		end else begin
			num = $signed({1'b0, HUE_BLUE}) * $signed({11'b0, delta})
				+ $signed({1'b0, HUE_SECTOR}) * ($signed({11'b0, red}) - $signed({11'b0, green}));
		end
		hnum = num[16:0];
		sprod = {8'd0, delta} * {8'd0, SAT_SCALE};

		// zero divisor only occurs with zero dividend; divide by one instead
		cell_d.hue.rem = hnum[16:8];
		cell_d.hue.dvs = (delta == 8'd0) ? 9'd1 : {delta, 1'b0};
		cell_d.hue.low = {hnum[7:0], 8'd0};
		cell_d.hue.quo = '0;
		cell_d.sat.rem = {1'b0, sprod[15:8]};
		cell_d.sat.dvs = (mx == 8'd0) ? 9'd1 : {1'b0, mx};
		cell_d.sat.low = {sprod[7:0], 8'd0};
		cell_d.sat.quo = '0;
		cell_d.val     = mx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s1 <= cell_d;
		end
	end

endmodule

/* hw/rtl/rhsv_div_cell.sv */
// ----------------------------------------------------------------------------
// rhsv_div_cell
// One quotient bit for both lanes, registered toward the next cell.
// ----------------------------------------------------------------------------
module rhsv_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  rhsv_pkg::rhsv_cell_t cell_in,
	output logic                 valid_q,
	output rhsv_pkg::rhsv_cell_t cell_q
);
	import rhsv_pkg::*;

	function automatic rhsv_lane_t step(input rhsv_lane_t l);
		logic [REM_W:0] t;
		rhsv_lane_t     o;
		t = {l.rem, l.low[QUO_W-1]};
		o = l;
		o.low = {l.low[QUO_W-2:0], 1'b0};
		if (t >= {1'b0, l.dvs}) begin
			o.rem = REM_W'(t - {1'b0, l.dvs});
			o.quo = {l.quo[QUO_W-2:0], 1'b1};
		end else begin
			o.rem = t[REM_W-1:0];
			o.quo = {l.quo[QUO_W-2:0], 1'b0};
		end
		return o;
	endfunction

	rhsv_cell_t cell_d;

	always_comb begin
		cell_d     = cell_in;
		cell_d.hue = step(cell_in.hue);
		cell_d.sat = step(cell_in.sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= cell_d;
		end
	end

endmodule

/* hw/rtl/rgb_to_hsv_pixel.sv */
// Stages: 1 front stage, then 16 divider cells that each resolve one quotient bit
// of hue and saturation. Throughput: one pixel per cycle unless backpressure stalls.
// Backpressure stalls the whole chain; input is taken while the output holds a result
// only if the chain can advance.
// Reset: asynchronous, clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit RGB to HSV with halved hue, fixed point with 8 fractional bits.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // hue_half[15:0], saturation[31:16], brightness[39:32]
);
	import rhsv_pkg::*;

	logic       en;
	logic       vld [NCELLS+1];
	rhsv_cell_t cel [NCELLS+1];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rhsv_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid),
		.red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
		.valid_s1(vld[0]), .cell_s1(cel[0])
	);

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		rhsv_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(vld[i]), .cell_in(cel[i]),
			.valid_q(vld[i+1]), .cell_q(cel[i+1])
		);
	end

	assign m_tvalid = vld[NCELLS];
	assign m_tdata  = {cel[NCELLS].val, cel[NCELLS].sat.quo, cel[NCELLS].hue.quo};

	// stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	// remainders stay below divisor at the output
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cel[NCELLS].hue.rem < cel[NCELLS].hue.dvs
			&& cel[NCELLS].sat.rem < cel[NCELLS].sat.dvs)
		else $error("division remainder out of range");
	// halved hue below 180, i.e. hue below 360 degrees
	a_hue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] < 16'd46080)
		else $error("hue out of range");

endmodule
